FILE: src/acs_pkg.sv
package acs_pkg;

	localparam int CP_W = 21;
	localparam int CH_W = 16;

	localparam logic [CH_W-1:0] LETTER_BASE = 16'h0621;
	localparam logic [CH_W-1:0] LAM         = 16'h0644;
	localparam logic [CH_W-1:0] TATWEEL     = 16'h0640;
	localparam logic [CH_W-1:0] ALEF_MAD    = 16'h0622;
	localparam logic [CH_W-1:0] ALEF_HAMZA  = 16'h0623;
	localparam logic [CH_W-1:0] ALEF_BELOW  = 16'h0625;
	localparam logic [CH_W-1:0] ALEF_PLAIN  = 16'h0627;
	localparam logic [CH_W-1:0] LIG_MADDA   = 16'hFEF5;
	localparam logic [CH_W-1:0] LIG_HAMZA   = 16'hFEF7;
	localparam logic [CH_W-1:0] LIG_BELOW   = 16'hFEF9;
	localparam logic [CH_W-1:0] LIG_PLAIN   = 16'hFEFB;

	// forms of one letter: isolated, initial, medial, final (0 = none)
	typedef struct packed {
		logic [CH_W-1:0] iso;
		logic [CH_W-1:0] ini;
		logic [CH_W-1:0] med;
		logic [CH_W-1:0] fin;
	} forms_t;

	// one result item
	typedef struct packed {
		logic [CP_W-1:0] code;
		logic            last;
		logic            ovf;
	} res_t;

	function automatic forms_t forms_of(input logic [CP_W-1:0] c);
		forms_t f;
		logic [5:0] i;
		f = '0;
		i = 6'(c - CP_W'(LETTER_BASE));
		if (c >= CP_W'(LETTER_BASE) && c < CP_W'(LETTER_BASE) + CP_W'(42)) begin
			case (i)
				6'd0: f = '{16'hFE80, 16'h0, 16'h0, 16'h0};
				6'd1: f = '{16'hFE81, 16'h0, 16'h0, 16'hFE82};
				6'd2: f = '{16'hFE83, 16'h0, 16'h0, 16'hFE84};
				6'd3: f = '{16'hFE85, 16'h0, 16'h0, 16'hFE86};
				6'd4: f = '{16'hFE87, 16'h0, 16'h0, 16'hFE88};
				6'd5: f = '{16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A};
				6'd6: f = '{16'hFE8D, 16'h0, 16'h0, 16'hFE8E};
				6'd7: f = '{16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90};
				6'd8: f = '{16'hFE93, 16'h0, 16'h0, 16'hFE94};
				6'd9: f = '{16'hFE95, 16'hFE97, 16'hFE98, 16'hFE96};
				6'd10: f = '{16'hFE99, 16'hFE9B, 16'hFE9C, 16'hFE9A};
				6'd11: f = '{16'hFE9D, 16'hFE9F, 16'hFEA0, 16'hFE9E};
				6'd12: f = '{16'hFEA1, 16'hFEA3, 16'hFEA4, 16'hFEA2};
				6'd13: f = '{16'hFEA5, 16'hFEA7, 16'hFEA8, 16'hFEA6};
				6'd14: f = '{16'hFEA9, 16'h0, 16'h0, 16'hFEAA};
				6'd15: f = '{16'hFEAB, 16'h0, 16'h0, 16'hFEAC};
				6'd16: f = '{16'hFEAD, 16'h0, 16'h0, 16'hFEAE};
				6'd17: f = '{16'hFEAF, 16'h0, 16'h0, 16'hFEB0};
				6'd18: f = '{16'hFEB1, 16'hFEB3, 16'hFEB4, 16'hFEB2};
				6'd19: f = '{16'hFEB5, 16'hFEB7, 16'hFEB8, 16'hFEB6};
				6'd20: f = '{16'hFEB9, 16'hFEBB, 16'hFEBC, 16'hFEBA};
				6'd21: f = '{16'hFEBD, 16'hFEBF, 16'hFEC0, 16'hFEBE};
				6'd22: f = '{16'hFEC1, 16'hFEC3, 16'hFEC4, 16'hFEC2};
				6'd23: f = '{16'hFEC5, 16'hFEC7, 16'hFEC8, 16'hFEC6};
				6'd24: f = '{16'hFEC9, 16'hFECB, 16'hFECC, 16'hFECA};
				6'd25: f = '{16'hFECD, 16'hFECF, 16'hFED0, 16'hFECE};
				6'd31: f = '{16'h0640, 16'h0, 16'h0, 16'h0};
				6'd32: f = '{16'hFED1, 16'hFED3, 16'hFED4, 16'hFED2};
				6'd33: f = '{16'hFED5, 16'hFED7, 16'hFED8, 16'hFED6};
				6'd34: f = '{16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA};
				6'd35: f = '{16'hFEDD, 16'hFEDF, 16'hFEE0, 16'hFEDE};
				6'd36: f = '{16'hFEE1, 16'hFEE3, 16'hFEE4, 16'hFEE2};
				6'd37: f = '{16'hFEE5, 16'hFEE7, 16'hFEE8, 16'hFEE6};
				6'd38: f = '{16'hFEE9, 16'hFEEB, 16'hFEEC, 16'hFEEA};
				6'd39: f = '{16'hFEED, 16'h0, 16'h0, 16'hFEEE};
				6'd40: f = '{16'hFEEF, 16'h0, 16'h0, 16'hFEF0};
				6'd41: f = '{16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2};
				default: f = '0;
			endcase
		end
		return f;
	endfunction

	function automatic logic is_mark(input logic [CP_W-1:0] c);
		return c == 21'h0610 || (c >= 21'h0612 && c <= 21'h0615) ||
			(c >= 21'h064B && c <= 21'h0658) || c == 21'h0670 ||
			(c >= 21'h06D6 && c <= 21'h06DC) || (c >= 21'h06DF && c <= 21'h06E4) ||
			c == 21'h06E7 || c == 21'h06E8 || (c >= 21'h06EA && c <= 21'h06ED);
	endfunction

	// isolated ligature code, 0 when not an alef that ligates
	function automatic logic [CH_W-1:0] lig_iso(input logic [CP_W-1:0] c);
		logic [CH_W-1:0] r;
		r = '0;
		if (c == CP_W'(ALEF_MAD)) r = LIG_MADDA;
		if (c == CP_W'(ALEF_HAMZA)) r = LIG_HAMZA;
		if (c == CP_W'(ALEF_BELOW)) r = LIG_BELOW;
		if (c == CP_W'(ALEF_PLAIN)) r = LIG_PLAIN;
		return r;
	endfunction

	// form of a finished letter
	function automatic logic [CH_W-1:0] pick_form(input forms_t f, input logic p,
			input logic n);
		logic [CH_W-1:0] r;
		if (p && n && f.med != '0) r = f.med;
		else if (p && f.fin != '0) r = f.fin;
		else if (n && f.ini != '0) r = f.ini;
		else r = f.iso;
		return r;
	endfunction

endpackage

FILE: src/acs_if.sv
interface acs_in_if;
	import acs_pkg::*;
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;
	logic            end_of_text;
	modport source (output valid, code_point, end_of_text, input ready);
	modport sink (input valid, code_point, end_of_text, output ready);
endinterface

interface acs_out_if;
	import acs_pkg::*;
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] shaped_code;
	logic            last_of_run;
	logic            mark_overflow;
	modport source (output valid, shaped_code, last_of_run, mark_overflow, input ready);
	modport sink (input valid, shaped_code, last_of_run, mark_overflow, output ready);
endinterface

FILE: src/arabic_contextual_shaper.sv
// Arabic contextual shaper.
// Results: the first result of an accepted item is pushed into the output register
// from the HEAD or TAIL state; an item causes 0 to MARK_DEPTH+2 results, and no
// new item is taken until all are sent. Results are sequenced one per cycle while
// the output register has room, marks read from the mark RAM one per cycle likewise.
// Reset: arst_n clears pending letter, mark count and the sequencer; mark RAM
// contents are not cleared.
module arabic_contextual_shaper #(
	parameter int MARK_DEPTH = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	acs_in_if.sink   in_ch,
	acs_out_if.source out_ch
);
	import acs_pkg::*;

	localparam int AW = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
	localparam int CW = $clog2(MARK_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_HEAD = 4'b0010,
		ST_MARK = 4'b0100,
		ST_TAIL = 4'b1000
	} st_t;

	st_t             st_q;
	logic [CH_W-1:0] pend_q;
	logic            pvalid_q, pjoin_q;
	logic [CW-1:0]   cnt_q, idx_q;
	// plan for the current item
	logic            tail_en_q, ovf_q;
	logic [CH_W-1:0] head_q;
	logic [CP_W-1:0] tail_q;

	logic            push, ofull;
	res_t            res;
	logic            we;
	logic [AW-1:0]   raddr;
	logic [CH_W-1:0] rdata;

	logic [CP_W-1:0] c;
	forms_t          fc, fp;
	logic            c_mark, c_letter, c_lig;

	assign c        = in_ch.code_point;
	assign fc       = forms_of(c);
	assign fp       = forms_of(CP_W'(pend_q));
	assign c_mark   = is_mark(c);
	assign c_letter = !c_mark && fc.iso != '0;
	assign c_lig    = pend_q == LAM && lig_iso(c) != '0;
	assign in_ch.ready = st_q == ST_IDLE;

	logic acc;
	assign acc = in_ch.valid && in_ch.ready;

	assign we    = acc && c_mark && pvalid_q && cnt_q < CW'(MARK_DEPTH);
	assign raddr = (st_q == ST_IDLE) ? '0 : AW'(idx_q + ((st_q == ST_HEAD || push)
		? CW'(st_q != ST_HEAD) : CW'(0)));

	acs_mark_ram #(.DEPTH(MARK_DEPTH), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(AW'(cnt_q)), .wdata(c[CH_W-1:0]),
		.raddr(raddr), .rdata(rdata)
	);

	acs_out_reg u_out (.clk(clk), .arst_n(arst_n), .push(push), .din(res),
		.full(ofull), .o(out_ch));

	// result selection per sequencer state
	always_comb begin
		push = 1'b0;
		res  = '0;
		res.ovf = ovf_q;
		case (st_q)
			ST_HEAD: begin
				push = !ofull;
				res.code = CP_W'(head_q);
				res.last = !tail_en_q && cnt_q == '0;
			end
			ST_MARK: begin
				push = !ofull;
				res.code = CP_W'(rdata);
				res.last = !tail_en_q && idx_q + CW'(1) == cnt_q;
			end
			ST_TAIL: begin
				push = !ofull;
				res.code = tail_q;
				res.last = 1'b1;
			end
			default: push = 1'b0;
		endcase
	end

	// decide the item, then step through its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; pend_q <= '0; pvalid_q <= 1'b0; pjoin_q <= 1'b0;
			cnt_q <= '0; idx_q <= '0; tail_en_q <= 1'b0;
			ovf_q <= 1'b0; head_q <= '0; tail_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						logic            fin_now, tl_en, ovf;
						logic            nxt_pv, nxt_pj;
						logic [CH_W-1:0] nxt_p, hd, eot_form;
						logic [CP_W-1:0] tl;
						logic [CW-1:0]   nxt_cnt;
						st_t             nxt_st;
						fin_now = 1'b0; tl_en = 1'b0; ovf = 1'b0;
						hd = head_q; tl = c; nxt_cnt = cnt_q;
						nxt_pv = pvalid_q; nxt_pj = pjoin_q; nxt_p = pend_q;
						if (c_mark) begin
							if (pvalid_q && cnt_q < CW'(MARK_DEPTH)) begin
								nxt_cnt = cnt_q + CW'(1);
							end else begin
								tl_en = 1'b1;
								if (pvalid_q) begin
									fin_now = 1'b1; ovf = 1'b1;
									hd = pick_form(fp, pjoin_q, 1'b0);
									nxt_pv = 1'b0; nxt_pj = 1'b0;
								end
							end
						end else if (c_letter) begin
							if (pvalid_q && c_lig) begin
								fin_now = 1'b1;
								hd = pjoin_q ? lig_iso(c) + CH_W'(1) : lig_iso(c);
								nxt_pv = 1'b0; nxt_pj = 1'b0;
							end else begin
								if (pvalid_q) begin
									fin_now = 1'b1;
									hd = pick_form(fp, pjoin_q,
										fc.med != '0 || fc.fin != '0 || c == CP_W'(TATWEEL));
								end else begin
									nxt_cnt = '0;
								end
								nxt_p = c[CH_W-1:0]; nxt_pv = 1'b1;
								nxt_pj = pvalid_q && (fp.ini != '0 || fp.med != '0);
							end
						end else begin
							tl_en = 1'b1;
							if (pvalid_q) begin
								fin_now = 1'b1;
								hd = pick_form(fp, pjoin_q, 1'b0);
								nxt_pv = 1'b0; nxt_pj = 1'b0;
							end
						end
						// end of text: finish whatever is still pending
						eot_form = pick_form(forms_of(CP_W'(nxt_p)), nxt_pj, 1'b0);
						if (in_ch.end_of_text && nxt_pv) begin
							if (fin_now) begin
								// new letter follows the old one and its marks
								tl_en = 1'b1;
								tl = CP_W'(eot_form);
							end else begin
								fin_now = 1'b1;
								hd = eot_form;
							end
						end
						if (in_ch.end_of_text) begin
							nxt_pv = 1'b0; nxt_pj = 1'b0; nxt_p = '0;
						end
						if (fin_now) nxt_st = ST_HEAD;
						else if (tl_en) nxt_st = ST_TAIL;
						else nxt_st = ST_IDLE;
						st_q <= nxt_st;
						pend_q <= nxt_p; pvalid_q <= nxt_pv; pjoin_q <= nxt_pj;
						cnt_q <= nxt_cnt; idx_q <= '0;
						head_q <= hd; tail_q <= tl;
						tail_en_q <= tl_en; ovf_q <= ovf;
					end
				end
				ST_HEAD: if (push) begin
					if (cnt_q != '0) begin
						st_q <= ST_MARK; idx_q <= '0;
					end else if (tail_en_q) st_q <= ST_TAIL;
					else st_q <= ST_IDLE;
				end
				ST_MARK: if (push) begin
					idx_q <= idx_q + CW'(1);
					if (!(idx_q + CW'(1) < cnt_q)) begin
						cnt_q <= '0;
						st_q <= tail_en_q ? ST_TAIL : ST_IDLE;
					end
				end
				ST_TAIL: if (push) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> st_q == ST_IDLE) else $error("ready outside idle");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !ofull) else $error("push into full output");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MARK_DEPTH)) else $error("mark count overrun");
	a_tail_last: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_TAIL && push) |-> res.last) else $error("tail not last");

endmodule

FILE: src/acs_mark_ram.sv
module acs_mark_ram #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [acs_pkg::CH_W-1:0] wdata,
	input  logic [AW-1:0]         raddr,
	output logic [acs_pkg::CH_W-1:0] rdata
);
	import acs_pkg::*;

	logic [CH_W-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: src/acs_out_reg.sv
module acs_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  acs_pkg::res_t     din,
	output logic              full,
	acs_out_if.source         o
);
	import acs_pkg::*;

	res_t data_q;
	logic full_q;

	// single output register; refills on the pop cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (push) begin
			full_q <= 1'b1;
		end else if (o.ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) data_q <= din;
	end

	assign full            = full_q && !o.ready;
	assign o.valid         = full_q;
	assign o.shaped_code   = data_q.code;
	assign o.last_of_run   = data_q.last;
	assign o.mark_overflow = data_q.ovf;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import acs_pkg::*;

	localparam int MARK_DEPTH = 8;

	logic clk;
	logic arst_n;
	logic failed;

	acs_in_if  in_ch();
	acs_out_if out_ch();

	arabic_contextual_shaper #(.MARK_DEPTH(MARK_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shaper state mirror
	logic [15:0] held_letter;
	logic        held_valid;
	logic        held_joins_back;
	logic [15:0] held_marks [MARK_DEPTH];
	int          held_mark_cnt;

	res_t shaped_queue[$];
	res_t step_out[$];

	typedef struct packed {
		logic [15:0] iso;
		logic [15:0] ini;
		logic [15:0] med;
		logic [15:0] fin;
	} glyph_forms_t;

	function automatic glyph_forms_t glyph_forms(input logic [CP_W-1:0] c);
		glyph_forms_t f;
		int k;
		f = '0;
		if (c >= 21'h0621 && c < 21'h0621 + 21'd42) begin
			k = int'(c) - 'h0621;
			if (k == 0) f.iso = 16'hFE80;
			else if (k <= 4) begin
				f.iso = 16'hFE81 + 16'((k - 1) * 2);
				f.fin = f.iso + 16'd1;
			end else if (k == 5) f = '{16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A};
			else if (k == 6) f = '{16'hFE8D, 16'h0, 16'h0, 16'hFE8E};
			else if (k == 7) f = '{16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90};
			else if (k == 8) f = '{16'hFE93, 16'h0, 16'h0, 16'hFE94};
			else if (k <= 13) begin
				f.iso = 16'hFE95 + 16'((k - 9) * 4);
				f.fin = f.iso + 16'd1; f.ini = f.iso + 16'd2; f.med = f.iso + 16'd3;
			end else if (k <= 17) begin
				f.iso = 16'hFEA9 + 16'((k - 14) * 2);
				f.fin = f.iso + 16'd1;
			end else if (k <= 25) begin
				f.iso = 16'hFEB1 + 16'((k - 18) * 4);
				f.fin = f.iso + 16'd1; f.ini = f.iso + 16'd2; f.med = f.iso + 16'd3;
			end else if (k == 31) f.iso = 16'h0640;
			else if (k >= 32 && k <= 38) begin
				f.iso = 16'hFED1 + 16'((k - 32) * 4);
				f.fin = f.iso + 16'd1; f.ini = f.iso + 16'd2; f.med = f.iso + 16'd3;
			end else if (k >= 39 && k <= 40) begin
				f.iso = 16'hFEED + 16'((k - 39) * 2);
				f.fin = f.iso + 16'd1;
			end else if (k == 41) f = '{16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2};
		end
		return f;
	endfunction

	function automatic bit transparent(input logic [CP_W-1:0] c);
		return c == 21'h610 || (c >= 21'h612 && c <= 21'h615) ||
			(c >= 21'h64B && c <= 21'h658) || c == 21'h670 ||
			(c >= 21'h6D6 && c <= 21'h6DC) || (c >= 21'h6DF && c <= 21'h6E4) ||
			c == 21'h6E7 || c == 21'h6E8 || (c >= 21'h6EA && c <= 21'h6ED);
	endfunction

	function automatic void push_code(input logic [CP_W-1:0] c);
		res_t r;
		r.code = c; r.last = 1'b0; r.ovf = 1'b0;
		step_out.push_back(r);
	endfunction

	function automatic void close_letter(input bit next_joins);
		glyph_forms_t f;
		logic [15:0] r;
		bit p;
		f = glyph_forms(CP_W'(held_letter));
		p = held_joins_back;
		if (p && next_joins && f.med != 0) r = f.med;
		else if (p && f.fin != 0) r = f.fin;
		else if (next_joins && f.ini != 0) r = f.ini;
		else r = f.iso;
		push_code(CP_W'(r));
		for (int i = 0; i < held_mark_cnt; i++) push_code(CP_W'(held_marks[i]));
		held_mark_cnt = 0;
		held_valid = 0;
		held_joins_back = 0;
	endfunction

	// shape one code point, appending its results to the expected queue
	function automatic void shape_char(input logic [CP_W-1:0] c, input bit eot);
		glyph_forms_t f, g;
		bit ovf, prev, take;
		logic [15:0] lig;
		step_out.delete();
		ovf = 0;
		f = glyph_forms(c);
		if (transparent(c)) begin
			if (held_valid) begin
				if (held_mark_cnt < MARK_DEPTH) begin
					held_marks[held_mark_cnt] = c[15:0];
					held_mark_cnt++;
				end else begin
					close_letter(0);
					push_code(c);
					ovf = 1;
				end
			end else push_code(c);
		end else if (f.iso != 0) begin
			prev = 0; take = 1; lig = 0;
			if (held_valid) begin
				if (held_letter == 16'h0644) begin
					case (c)
						21'h0622: lig = 16'hFEF5;
						21'h0623: lig = 16'hFEF7;
						21'h0625: lig = 16'hFEF9;
						21'h0627: lig = 16'hFEFB;
						default: lig = 0;
					endcase
					if (lig != 0 && held_joins_back) lig++;
				end
				if (lig != 0) begin
					push_code(CP_W'(lig));
					for (int i = 0; i < held_mark_cnt; i++) push_code(CP_W'(held_marks[i]));
					held_mark_cnt = 0; held_valid = 0; held_joins_back = 0; take = 0;
				end else begin
					g = glyph_forms(CP_W'(held_letter));
					prev = (g.ini != 0 || g.med != 0);
					close_letter(f.med != 0 || f.fin != 0 || c == 21'h0640);
				end
			end
			if (take) begin
				held_letter = c[15:0]; held_valid = 1; held_joins_back = prev;
				held_mark_cnt = 0;
			end
		end else begin
			if (held_valid) close_letter(0);
			push_code(c);
		end
		if (eot) begin
			if (held_valid) close_letter(0);
			held_letter = 0; held_valid = 0; held_joins_back = 0; held_mark_cnt = 0;
		end
		foreach (step_out[i]) begin
			step_out[i].ovf = ovf;
			step_out[i].last = (i == step_out.size() - 1);
			shaped_queue.push_back(step_out[i]);
		end
	endfunction

	// result checker with random stall
	int out_stall;
	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_stall = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (shaped_queue.size() == 0) begin
					$error("unexpected item code=%h", out_ch.shaped_code);
					failed = 1;
				end else begin
					e = shaped_queue.pop_front();
					if (e.code != out_ch.shaped_code) begin
						$error("shaped_code exp %h got %h", e.code, out_ch.shaped_code);
						failed = 1;
					end
					if (e.last != out_ch.last_of_run) begin
						$error("last_of_run exp %b got %b", e.last, out_ch.last_of_run);
						failed = 1;
					end
					if (e.ovf != out_ch.mark_overflow) begin
						$error("mark_overflow exp %b got %b", e.ovf, out_ch.mark_overflow);
						failed = 1;
					end
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					out_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20)
						: $urandom_range(1, 2);
			end
		end
	end

	bit quiet_phase;

	// valid stays high between back-to-back items; a gap drops it first
	task automatic send_char(input logic [CP_W-1:0] c, input bit eot);
		int gap;
		gap = quiet_phase ? 0 : (($urandom_range(0, 3) != 0) ? 0 :
			(($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 2)));
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.code_point <= c;
		in_ch.end_of_text <= eot;
		shape_char(c, eot);
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// stop sending and wait until every expected result has come
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (shaped_queue.size() != 0) @(posedge clk);
	endtask

	function automatic logic [CP_W-1:0] rand_letter();
		logic [CP_W-1:0] c;
		do c = 21'h0621 + 21'($urandom_range(0, 41));
		while (glyph_forms(c).iso == 0);
		return c;
	endfunction

	function automatic logic [CP_W-1:0] rand_mark();
		case ($urandom_range(0, 4))
			0: return 21'h0610;
			1: return 21'h064B + 21'($urandom_range(0, 13));
			2: return 21'h06D6 + 21'($urandom_range(0, 6));
			3: return 21'h06DF + 21'($urandom_range(0, 5));
			default: return 21'h06EA + 21'($urandom_range(0, 3));
		endcase
	endfunction

	function automatic logic [CP_W-1:0] rand_alef();
		case ($urandom_range(0, 3))
			0: return 21'h0622;
			1: return 21'h0623;
			2: return 21'h0625;
			default: return 21'h0627;
		endcase
	endfunction

	function automatic logic [CP_W-1:0] rand_other();
		case ($urandom_range(0, 2))
			0: return 21'($urandom_range(0, 'h1FFFFF));
			1: return 21'($urandom_range(0, 'h7F));
			default: return 21'h0600 + 21'($urandom_range(0, 'hFF));
		endcase
	endfunction

	// has_exp rows give their single result directly
	typedef struct {
		logic [CP_W-1:0] c;
		bit              eot;
		bit              has_exp;
		logic [CP_W-1:0] exp;
	} stim_row_t;

	stim_row_t directed_rows[] = '{
		'{21'h000000, 1'b0, 1'b1, 21'h000000},
		'{21'h1FFFFF, 1'b0, 1'b1, 21'h1FFFFF},
		'{21'h10FFFF, 1'b1, 1'b1, 21'h10FFFF},
		'{21'h0650, 1'b0, 1'b1, 21'h0650},                        // mark, nothing held
		'{21'h0628, 1'b0, 1'b0, '0}, '{21'h0628, 1'b0, 1'b0, '0},
		'{21'h0628, 1'b1, 1'b0, '0},                              // ini, med, fin
		'{21'h0644, 1'b0, 1'b0, '0}, '{21'h0627, 1'b1, 1'b0, '0}, // isolated lam-alef
		'{21'h0628, 1'b0, 1'b0, '0}, '{21'h0644, 1'b0, 1'b0, '0},
		'{21'h064E, 1'b0, 1'b0, '0},
		'{21'h0651, 1'b0, 1'b0, '0}, '{21'h0622, 1'b0, 1'b0, '0}, // final ligature, marks
		'{21'h0628, 1'b1, 1'b0, '0},                              // no join after ligature
		'{21'h0640, 1'b0, 1'b0, '0}, '{21'h0621, 1'b0, 1'b0, '0},
		'{21'h0644, 1'b0, 1'b0, '0}, '{21'h0625, 1'b1, 1'b0, '0},
		'{21'h0646, 1'b0, 1'b0, '0}, '{21'h0623, 1'b0, 1'b0, '0},
		'{21'h0041, 1'b0, 1'b0, '0}, '{21'h06ED, 1'b1, 1'b0, '0}
	};

	// stimulus
	initial begin
		int n;
		failed = 0;
		quiet_phase = 0;
		held_letter = 0; held_valid = 0; held_joins_back = 0; held_mark_cnt = 0;
		in_ch.valid = 1'b0;
		in_ch.code_point = '0;
		in_ch.end_of_text = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_char(directed_rows[i].c, directed_rows[i].eot);
			if (directed_rows[i].has_exp) begin
				void'(shaped_queue.pop_back());
				shaped_queue.push_back(res_t'{directed_rows[i].exp, 1'b1, 1'b0});
			end
		end
		// fill the mark buffer and overflow it
		send_char(21'h0633, 1'b0);
		repeat (MARK_DEPTH) send_char(21'h064B, 1'b0);
		send_char(21'h06E8, 1'b0);
		send_char(21'h0628, 1'b1);

		// wait until drained
		drain();

		// random words
		n = 0;
		while (n < 320) begin
			int len;
			quiet_phase = ($urandom_range(0, 7) == 0);
			len = $urandom_range(1, 10);
			for (int k = 0; k < len; k++) begin
				int sel;
				logic [CP_W-1:0] c;
				sel = $urandom_range(0, 19);
				if (sel < 9) c = rand_letter();
				else if (sel < 11) c = 21'h0644;
				else if (sel < 13) c = rand_alef();
				else if (sel < 17) c = rand_mark();
				else c = rand_other();
				send_char(c, k == len - 1 && $urandom_range(0, 1));
				n++;
				if (sel == 15 && $urandom_range(0, 5) == 0) begin
					repeat ($urandom_range(MARK_DEPTH - 1, MARK_DEPTH + 1)) begin
						send_char(rand_mark(), 1'b0);
						n++;
					end
				end
			end
			if (n > 160 && n < 172)
				drain();
		end
		send_char(21'h0020, 1'b1);

		drain();
		repeat (20) @(posedge clk);
		if (!failed)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// timeout
	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
